// ----- design/flat_top_window_engine_defines.svh -----
// assertion macros used by the port-level checker file
`ifndef FLAT_TOP_WINDOW_ENGINE_DEFINES_SVH
`define FLAT_TOP_WINDOW_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FTWE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FTWE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ftwe_pkg.sv -----
// types, constants and helper functions of the flat-top window engine
package ftwe_pkg;

	localparam int MAX_LENGTH = 4096;
	localparam int ADDR_W     = $clog2(MAX_LENGTH);
	localparam int LEN_W      = 13;
	localparam int COEF_W     = 16;
	localparam int CW         = 34;
	localparam int DIV_W      = 44;
	localparam int SUM_W      = 30;
	localparam int SQ_W       = 44;
	localparam int CORDIC_STEPS = 31;
	localparam int MIN_LENGTH = 5;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
	localparam logic [31:0] QUARTER_TURN         = 32'h4000_0000;
	localparam logic signed [63:0] ACC_INIT      = 64'sd231476135 * 64'sd1073741824;
	localparam logic [63:0] ROUND_HALF_Q45       = 64'd17592186044416;

	typedef struct packed {
		logic              op;
		logic signed [15:0] sample_in;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] windowed_sample;
		logic               frame_last;
		logic               status;
		logic [14:0]        coherent_gain;
		logic [30:0]        power_gain;
	} out_word_t;

	localparam logic OP_BUILD  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;
	localparam logic ST_OK     = 1'b0;
	localparam logic ST_ERR    = 1'b1;

	// arctangent of 2^-k in 2^32 turns
	function automatic logic [31:0] atan_turn(input logic [4:0] k);
		logic [31:0] a;
		case (k)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			5'd30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// window weight of cosine term t+1
	function automatic logic [29:0] term_weight(input logic [1:0] t);
		logic [29:0] w;
		case (t)
			2'd0: w = 30'd447354753;
			2'd1: w = 30'd297709049;
			2'd2: w = 30'd89742211;
			2'd3: w = 30'd7459680;
			default: w = 30'd0;
		endcase
		return w;
	endfunction

	// arithmetic shift right truncating toward zero
	function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
		input logic [4:0] s);
		logic [CW-1:0] m;
		m = v[CW-1] ? CW'(-v) : CW'(v);
		m = m >> s;
		return v[CW-1] ? $signed(CW'(-m)) : $signed(m);
	endfunction

endpackage

// ----- design/ftwe_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module ftwe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/flat_top_window_engine.sv -----
// flat-top window engine: coefficient table build, gains and sample windowing
// sample word: ram read registered at accept, then multiply in S_MUL into the result register; no new word until idle
// build word: one phase division, then per coefficient 4 cosines on the shared 31-step cordic,
//   then the coherent and power gain divisions on the shared bit-serial divider
// bad length or sample before build: error word registered at accept
// reset clears control state only; table contents undefined until the first build
module flat_top_window_engine
	import ftwe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data
);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_MUL     = 12'b0000_0000_0010,
		S_DIVSTEP = 12'b0000_0000_0100,
		S_CINIT   = 12'b0000_0000_1000,
		S_CORD    = 12'b0000_0001_0000,
		S_CMUL    = 12'b0000_0010_0000,
		S_CACC    = 12'b0000_0100_0000,
		S_CRND    = 12'b0000_1000_0000,
		S_CMIR    = 12'b0001_0000_0000,
		S_GSET    = 12'b0010_0000_0000,
		S_DIVCG   = 12'b0100_0000_0000,
		S_DIVPG   = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic [LEN_W-1:0]  wlen_q, blen_q, len_q;
	logic              built_q;
	logic [ADDR_W-1:0] pos_q;
	logic              out_valid_q;
	out_word_t         out_word_q;
	logic              last_s1;
	logic signed [15:0] sample_s1;

	// divider
	logic [DIV_W-1:0] div_num_q;
	logic [LEN_W-1:0] div_rem_q, div_den_q;
	logic [5:0]       div_cnt_q;
	logic [LEN_W:0]   div_trial;
	logic             div_ge;
	logic [LEN_W-1:0] div_rem_n;
	logic [DIV_W-1:0] div_num_n;
	logic             div_last;

	// phase generator and coefficient loop
	logic [31:0]       step_q, phase_q;
	logic [LEN_W-1:0]  rstep_q, prem_q;
	logic [ADDR_W-1:0] i_q;
	logic [1:0]        t_q;

	// cordic
	logic signed [CW-1:0] x_q, y_q, rest_q;
	logic [4:0]           k_q;
	logic                 neg_q;
	logic signed [63:0]   prod_q, acc_q;
	logic signed [COEF_W-1:0] coef_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]          sq_q;
	logic [14:0]              cg_q;

	logic in_acc, len_bad;
	logic [31:0] tp;
	logic [1:0]  quad;
	logic [30:0] red;
	logic signed [CW-1:0] dx, dy, atan_k, xc;
	logic signed [31:0]   cval;
	logic signed [62:0]   term_prod;
	logic [63:0]          mag;
	logic [18:0]          rnd;
	logic signed [COEF_W-1:0] coef_n;
	logic [ADDR_W-1:0] mirror;
	logic              mid;
	logic [LEN_W-1:0]  half;
	logic              last_i;
	logic [LEN_W:0]    prem_sum;
	logic [LEN_W-1:0]  len_m1;
	logic              carry;
	logic [31:0]       csq;
	logic signed [SUM_W-1:0] sum_adj;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [COEF_W-1:0] ram_wdata, ram_rdata;
	logic signed [31:0] sprod;
	logic [31:0]       smag;
	logic [16:0]       srnd;
	logic signed [15:0] swin;
	logic              pos_last;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign len_bad   = (wlen_q < LEN_W'(MIN_LENGTH)) || (wlen_q > LEN_W'(MAX_LENGTH));

	// shared restoring divider step
	assign div_trial = {div_rem_q, div_num_q[DIV_W-1]};
	assign div_ge    = div_trial >= {1'b0, div_den_q};
	assign div_rem_n = div_ge ? LEN_W'(div_trial - {1'b0, div_den_q}) : div_trial[LEN_W-1:0];
	assign div_num_n = {div_num_q[DIV_W-2:0], div_ge};
	assign div_last  = div_cnt_q == 6'(DIV_W - 1);

	// term phase and quadrant folding
	assign tp   = 32'(phase_q * {30'd0, t_q} + phase_q);
	assign quad = tp[31:30];
	assign red  = (quad == 2'd0 || quad == 2'd2) ? {1'b0, tp[29:0]}
		: 31'(QUARTER_TURN - {2'b00, tp[29:0]});

	// cordic rotation step
	assign dx     = shr_tz(y_q, k_q);
	assign dy     = shr_tz(x_q, k_q);
	assign atan_k = $signed({2'b00, atan_turn(k_q)});

	// clamp, sign and weight of one cosine
	assign xc        = (x_q > ONE_Q30) ? ONE_Q30 : (x_q[CW-1] ? '0 : x_q);
	assign cval      = neg_q ? 32'(-xc) : 32'(xc);
	assign term_prod = $signed({1'b0, term_weight(t_q)}) * cval;

	// round half away from zero to q15 and saturate
	assign mag    = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
	assign rnd    = 19'((mag + ROUND_HALF_Q45) >> 45);
	assign coef_n = acc_q[63] ? ((rnd > 19'd32768) ? -16'sd32768 : $signed(16'(-rnd)))
		: ((rnd > 19'd32767) ? 16'sd32767 : $signed(16'(rnd)));

	// mirror address and loop end
	assign mirror = ADDR_W'(len_q - LEN_W'(1) - LEN_W'(i_q));
	assign mid    = mirror == i_q;
	assign half   = LEN_W'(({1'b0, len_q} + 14'd1) >> 1);
	assign last_i = (LEN_W'(i_q) + LEN_W'(1)) == half;
	assign len_m1 = len_q - LEN_W'(1);
	assign prem_sum = {1'b0, prem_q} + {1'b0, rstep_q};
	assign carry  = prem_sum >= {1'b0, len_m1};
	assign csq    = 32'(coef_q * coef_q);
	assign sum_adj = sum_q + SUM_W'(len_q >> 1);

	// sample multiply with rounding and saturation
	assign sprod = sample_s1 * $signed(ram_rdata);
	assign smag  = sprod[31] ? 32'(-sprod) : 32'(sprod);
	assign srnd  = 17'((smag + 32'd16384) >> 15);
	assign swin  = sprod[31] ? $signed(16'(-srnd))
		: ((srnd > 17'd32767) ? 16'sd32767 : $signed(16'(srnd)));
	assign pos_last = (LEN_W'(pos_q) + LEN_W'(1)) >= blen_q;

	// table memory ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_wdata = coef_n;
		case (state_q)
			S_CRND: ram_we = 1'b1;
			S_CMIR: begin
				ram_we    = 1'b1;
				ram_waddr = mirror;
				ram_wdata = coef_q;
			end
			default: ram_we = 1'b0;
		endcase
	end
	assign ram_re = in_acc && (in_word.op == OP_SAMPLE) && built_q;

	ftwe_ram #(
		.WIDTH(COEF_W),
		.DEPTH(MAX_LENGTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= LEN_W'(1024);
		end else if (cfg_wr_en) begin
			wlen_q <= cfg_wr_data;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			built_q     <= 1'b0;
			blen_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
			k_q         <= '0;
			t_q         <= '0;
			i_q         <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_word.op == OP_BUILD) begin
							if (len_bad) begin
								out_valid_q <= 1'b1;
							end else begin
								div_cnt_q <= '0;
								state_q   <= S_DIVSTEP;
							end
						end else if (!built_q) begin
							out_valid_q <= 1'b1;
						end else begin
							pos_q   <= pos_last ? '0 : ADDR_W'(pos_q + 1'b1);
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_DIVSTEP: begin
					div_cnt_q <= 6'(div_cnt_q + 1'b1);
					if (div_last) begin
						i_q     <= '0;
						t_q     <= '0;
						state_q <= S_CINIT;
					end
				end
				S_CINIT: begin
					k_q     <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					k_q <= 5'(k_q + 1'b1);
					if (k_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= S_CMUL;
					end
				end
				S_CMUL: state_q <= S_CACC;
				S_CACC: begin
					t_q     <= 2'(t_q + 1'b1);
					state_q <= (t_q == 2'd3) ? S_CRND : S_CINIT;
				end
				S_CRND: state_q <= S_CMIR;
				S_CMIR: begin
					i_q     <= ADDR_W'(i_q + 1'b1);
					state_q <= last_i ? S_GSET : S_CINIT;
				end
				S_GSET: begin
					div_cnt_q <= '0;
					state_q   <= S_DIVCG;
				end
				S_DIVCG: begin
					div_cnt_q <= 6'(div_cnt_q + 1'b1);
					if (div_last) begin
						div_cnt_q <= '0;
						state_q   <= S_DIVPG;
					end
				end
				S_DIVPG: begin
					div_cnt_q <= 6'(div_cnt_q + 1'b1);
					if (div_last) begin
						built_q     <= 1'b1;
						blen_q      <= len_q;
						pos_q       <= '0;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sample_s1 <= in_word.sample_in;
				last_s1   <= pos_last;
				len_q     <= wlen_q;
				div_num_q <= DIV_W'(64'h1_0000_0000);
				div_rem_q <= '0;
				div_den_q <= wlen_q - LEN_W'(1);
				if (in_acc && (in_word.op == OP_BUILD || !built_q)) begin
					out_word_q        <= '0;
					out_word_q.status <= ST_ERR;
				end
			end
			S_MUL: begin
				out_word_q                 <= '0;
				out_word_q.windowed_sample <= swin;
				out_word_q.frame_last      <= last_s1;
				out_word_q.status          <= ST_OK;
			end
			S_DIVSTEP: begin
				div_num_q <= div_num_n;
				div_rem_q <= div_rem_n;
				step_q    <= div_num_n[31:0];
				rstep_q   <= div_rem_n;
				phase_q   <= '0;
				prem_q    <= '0;
				acc_q     <= ACC_INIT;
				sum_q     <= '0;
				sq_q      <= '0;
			end
			S_CINIT: begin
				x_q    <= CORDIC_GAIN;
				y_q    <= '0;
				rest_q <= $signed({3'b000, red});
				neg_q  <= (quad == 2'd1) || (quad == 2'd2);
			end
			S_CORD: begin
				if (!rest_q[CW-1]) begin
					x_q    <= x_q - dx;
					y_q    <= y_q + dy;
					rest_q <= rest_q - atan_k;
				end else begin
					x_q    <= x_q + dx;
					y_q    <= y_q - dy;
					rest_q <= rest_q + atan_k;
				end
			end
			S_CMUL: prod_q <= 64'(term_prod);
			S_CACC: acc_q <= t_q[0] ? acc_q + prod_q : acc_q - prod_q;
			S_CRND: coef_q <= coef_n;
			S_CMIR: begin
				sum_q   <= sum_q + (mid ? SUM_W'(coef_q) : SUM_W'(coef_q) <<< 1);
				sq_q    <= sq_q + (mid ? SQ_W'(csq) : SQ_W'(csq) << 1);
				prem_q  <= carry ? LEN_W'(prem_sum - {1'b0, len_m1}) : LEN_W'(prem_sum);
				phase_q <= 32'(phase_q + step_q + {31'd0, carry});
				acc_q   <= ACC_INIT;
			end
			S_GSET: begin
				div_num_q <= sum_adj[SUM_W-1] || (sum_adj == '0) ? '0 : DIV_W'(sum_adj);
				div_rem_q <= '0;
				div_den_q <= len_q;
			end
			S_DIVCG: begin
				div_num_q <= div_num_n;
				div_rem_q <= div_rem_n;
				if (div_last) begin
					cg_q      <= (div_num_n > DIV_W'(32767)) ? 15'd32767 : div_num_n[14:0];
					div_num_q <= sq_q + SQ_W'(len_q >> 1);
					div_rem_q <= '0;
				end
			end
			S_DIVPG: begin
				div_num_q <= div_num_n;
				div_rem_q <= div_rem_n;
				if (div_last) begin
					out_word_q               <= '0;
					out_word_q.status        <= ST_OK;
					out_word_q.coherent_gain <= cg_q;
					out_word_q.power_gain    <= div_num_n[30:0];
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

endmodule

// ----- design/ftwe_checker.sv -----
// port-level checker for the flat-top window engine and its bind
`include "flat_top_window_engine_defines.svh"

module ftwe_checker
	import ftwe_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input out_word_t        out_word
);

	// a stalled result word holds
	`FTWE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "result word changed while stalled")

	// no word is taken while a result word is blocked
	`FTWE_ASSERT_NOW(a_no_accept_blocked, in_valid && !in_stall, !(out_valid && out_stall), "input accepted with output blocked")

	// frame end words carry no gains and no error
	`FTWE_ASSERT_NOW(a_last_clean, out_valid && out_word.frame_last, (out_word.status == ST_OK) && (out_word.coherent_gain == 15'd0) && (out_word.power_gain == 31'd0), "frame end word carries gains or error")

	// error words carry no sample, no frame end and no power gain
	`FTWE_ASSERT_NOW(a_err_clean, out_valid && (out_word.status == ST_ERR), (out_word.windowed_sample == 16'sd0) && !out_word.frame_last && (out_word.power_gain == 31'd0), "error word carries data")

endmodule

bind flat_top_window_engine ftwe_checker u_ftwe_checker (.*);

// ----- tb/ftwe_checker.sv -----
// checker for the flat-top window engine: watches both channels, predicts and compares
module ftwe_scoreboard
	import ftwe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  in_word_t         in_word,
	input  logic             out_valid,
	input  logic             out_stall,
	input  out_word_t        out_word,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	output int               fails,
	output int               pending,
	output int               builds_ok,
	output int               builds_bad,
	output int               samples_ok,
	output int               samples_bad
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint UNIT_Q30 = 64'sd1073741824;
	localparam longint W0 = 64'sd231476135;
	localparam longint W1 = 64'sd447354753;
	localparam longint W2 = 64'sd297709049;
	localparam longint W3 = 64'sd89742211;
	localparam longint W4 = 64'sd7459680;
	localparam longint unsigned Q45 = 64'd35184372088832;

	localparam logic [31:0] ARC [0:30] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001};

	// predicted engine state
	logic signed [15:0] coef_mem [0:MAX_LENGTH-1];
	bit                 have_table;
	int                 table_len;
	int                 frame_pos;
	logic [LEN_W-1:0]   len_reg;
	out_word_t          result_q [$];
	int                 result_idx;

	// truncating shift toward zero
	function automatic longint shift_tz(longint v, int s);
		return (v >= 0) ? (v >>> s) : -((-v) >>> s);
	endfunction

	// rotation-based cosine for an angle within the first quadrant
	function automatic longint cos_quadrant(longint angle);
		longint x, y, rest, dx, dy;
		x = GAIN_Q30;
		y = 0;
		rest = angle;
		for (int k = 0; k < 31; k++) begin
			dx = shift_tz(y, k);
			dy = shift_tz(x, k);
			if (rest >= 0) begin
				x -= dx; y += dy; rest -= longint'(ARC[k]);
			end else begin
				x += dx; y -= dy; rest += longint'(ARC[k]);
			end
		end
		if (x > UNIT_Q30) x = UNIT_Q30;
		if (x < 0) x = 0;
		return x;
	endfunction

	// full-turn cosine by quadrant folding
	function automatic longint cos_turn(logic [31:0] ph);
		logic [1:0]  quad;
		logic [31:0] off, red;
		longint      c;
		quad = ph[31:30];
		off = {2'b00, ph[29:0]};
		red = (quad == 2'd0 || quad == 2'd2) ? off : (32'h40000000 - off);
		c = cos_quadrant(longint'(red));
		return (quad == 2'd1 || quad == 2'd2) ? -c : c;
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v[15:0];
	endfunction

	// one window coefficient from its phase
	function automatic logic signed [15:0] window_coef(logic [31:0] ph);
		longint acc, r;
		longint unsigned mag;
		logic [31:0] p2, p3, p4;
		p2 = ph * 32'd2;
		p3 = ph * 32'd3;
		p4 = ph * 32'd4;
		acc = W0 * UNIT_Q30;
		acc -= W1 * cos_turn(ph);
		acc += W2 * cos_turn(p2);
		acc -= W3 * cos_turn(p3);
		acc += W4 * cos_turn(p4);
		mag = (acc >= 0) ? acc : -acc;
		r = longint'((mag + Q45 / 2) / Q45);
		return clip16(acc >= 0 ? r : -r);
	endfunction

	// q15 product rounded away from zero
	function automatic logic signed [15:0] window_mul(int s, int c);
		int p, r;
		p = s * c;
		r = (p >= 0) ? (p + 16384) / 32768 : -((-p + 16384) / 32768);
		return clip16(r);
	endfunction

	// table build with gain report
	task automatic build_table(output out_word_t r);
		int              len, half;
		longint          sum, cg;
		longint unsigned sq, ph;
		logic signed [15:0] c;
		r = '0;
		len = len_reg;
		if (len < MIN_LENGTH || len > MAX_LENGTH) begin
			r.status = ST_ERR;
			builds_bad++;
			return;
		end
		half = (len + 1) / 2;
		for (int i = 0; i < half; i++) begin
			ph = (longint'(i) << 32) / longint'(len - 1);
			c = window_coef(ph[31:0]);
			coef_mem[i] = c;
			coef_mem[len - 1 - i] = c;
		end
		sum = 0;
		sq = 0;
		for (int i = 0; i < len; i++) begin
			sum += coef_mem[i];
			sq += longint'(int'(coef_mem[i]) * int'(coef_mem[i]));
		end
		sum += len / 2;
		cg = (sum <= 0) ? 0 : sum / len;
		if (cg > 32767) cg = 32767;
		have_table = 1;
		table_len = len;
		frame_pos = 0;
		r.status = ST_OK;
		r.coherent_gain = cg[14:0];
		r.power_gain = 31'((sq + longint'(len / 2)) / longint'(len));
		builds_ok++;
	endtask

	// one windowed sample
	task automatic window_sample(input logic signed [15:0] s, output out_word_t r);
		r = '0;
		if (!have_table) begin
			r.status = ST_ERR;
			samples_bad++;
			return;
		end
		if (frame_pos >= table_len) frame_pos = 0;
		r.windowed_sample = window_mul(int'(s), int'(coef_mem[frame_pos]));
		if (frame_pos + 1 >= table_len) begin
			r.frame_last = 1'b1;
			frame_pos = 0;
		end else begin
			frame_pos++;
		end
		samples_ok++;
	endtask

	task automatic report(string field, longint want, longint got);
		$display("mismatch: result %0d field %s expected %0d got %0d",
			result_idx, field, want, got);
		fails++;
	endtask

	// predict on accepted input words, compare on accepted output words
	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			have_table = 0;
			table_len = 0;
			frame_pos = 0;
			len_reg = 13'd1024;
			result_q.delete();
			pending = 0;
			fails = 0;
			result_idx = 0;
			builds_ok = 0;
			builds_bad = 0;
			samples_ok = 0;
			samples_bad = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (in_word.op == OP_BUILD) build_table(e);
				else window_sample(in_word.sample_in, e);
				result_q.push_back(e);
			end
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					// word arrived with nothing expected
					report("words_outstanding", 0, 1);
				end else begin
					e = result_q.pop_front();
					if (out_word.windowed_sample !== e.windowed_sample)
						report("windowed_sample", e.windowed_sample, out_word.windowed_sample);
					if (out_word.frame_last !== e.frame_last)
						report("frame_last", e.frame_last, out_word.frame_last);
					if (out_word.status !== e.status)
						report("status", e.status, out_word.status);
					if (out_word.coherent_gain !== e.coherent_gain)
						report("coherent_gain", e.coherent_gain, out_word.coherent_gain);
					if (out_word.power_gain !== e.power_gain)
						report("power_gain", e.power_gain, out_word.power_gain);
				end
				result_idx++;
			end
			if (cfg_wr_en) len_reg = cfg_wr_data;
			pending = result_q.size();
		end
	end

endmodule

// ----- tb/tb_flat_top_window_engine.sv -----
// testbench top for the flat-top window engine: clock, reset, stimulus and verdict
module tb_flat_top_window_engine;
	import ftwe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 1500000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_word_t         in_word;
	logic             out_valid;
	logic             out_stall;
	out_word_t        out_word;
	logic             cfg_wr_en;
	logic [LEN_W-1:0] cfg_wr_data;

	int fails, pending, builds_ok, builds_bad, samples_ok, samples_bad;
	int words_sent;
	int calm_left;
	int idle_cycles;

	flat_top_window_engine uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	ftwe_scoreboard chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fails(fails), .pending(pending),
		.builds_ok(builds_ok), .builds_bad(builds_bad),
		.samples_ok(samples_ok), .samples_bad(samples_bad)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// gap before the next input word, with calm stretches of none
	function automatic int sender_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) calm_left = $urandom_range(20, 100);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	function automatic logic signed [15:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return 16'sh7FFF;
		if (r < 6) return 16'sh8000;
		if (r < 8) return 16'sh0000;
		if (r < 10) return 16'shFFFF;
		return 16'($urandom);
	endfunction

	// one input word, valid kept high across back-to-back words
	task automatic send_word(logic op, logic signed [15:0] s);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= '{op: op, sample_in: s};
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// hold off until every result is back, then a short settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_length(int len);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= LEN_W'(len);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// random pick of a frame length, mostly short
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 78) return $urandom_range(5, 40);
		if (r < 91) return $urandom_range(41, 200);
		if (r < 95) return $urandom_range(0, 4);
		if (r < 98) return $urandom_range(4097, 8191);
		return (r == 98) ? 5 : 6;
	endfunction

	// receiver stall pattern
	initial begin
		int hold, r;
		bit st;
		hold = 0;
		st = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					st = 0; hold = $urandom_range(10, 80);
				end else if (r < 85) begin
					st = 1; hold = $urandom_range(1, 3);
				end else if (r < 97) begin
					st = 0; hold = $urandom_range(1, 6);
				end else begin
					st = 1; hold = $urandom_range(20, 60);
				end
			end
			out_stall <= st;
		end
	end

	// watchdog on cycles with no handshake
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int len, frames, extra, n;
		in_valid = 1'b0;
		in_word = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		words_sent = 0;
		calm_left = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// samples before any build
		send_word(OP_SAMPLE, 16'sh7FFF);
		send_word(OP_SAMPLE, 16'sh8000);
		// build at the reset length
		send_word(OP_BUILD, 16'sh1234);
		send_word(OP_SAMPLE, 16'sh8000);
		send_word(OP_SAMPLE, 16'sh7FFF);
		send_word(OP_SAMPLE, 16'sh0000);
		// bad lengths leave the table alone
		set_length(0);
		send_word(OP_BUILD, 16'sh0000);
		set_length(4);
		send_word(OP_BUILD, 16'sh7FFF);
		set_length(4097);
		send_word(OP_BUILD, 16'sh8000);
		set_length(8191);
		send_word(OP_BUILD, 16'shFFFF);
		send_word(OP_SAMPLE, 16'sh7FFF);
		send_word(OP_SAMPLE, 16'sh8000);
		// largest table
		set_length(MAX_LENGTH);
		send_word(OP_BUILD, 16'sh0000);
		send_word(OP_SAMPLE, 16'sh7FFF);
		send_word(OP_SAMPLE, 16'sh8000);
		// shortest table, frame wrap
		set_length(MIN_LENGTH);
		send_word(OP_BUILD, 16'sh0000);
		for (int i = 0; i < 7; i++) send_word(OP_SAMPLE, (i % 2) ? 16'sh8000 : 16'sh7FFF);
		// register change without a rebuild keeps the old frame
		set_length(9);
		for (int i = 0; i < 6; i++) send_word(OP_SAMPLE, pick_sample());

		// random phases: a build then mostly whole frames, some noise
		while (words_sent < 1500) begin
			len = pick_length();
			set_length(len);
			send_word(OP_BUILD, pick_sample());
			if ($urandom_range(0, 9) == 0) begin
				drain();
				continue;
			end
			frames = $urandom_range(1, 3);
			extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
			n = ((len >= 5 && len <= 200) ? len : 20) * frames + extra;
			for (int i = 0; i < n && words_sent < 1500; i++) begin
				if ($urandom_range(0, 99) < 2) send_word(OP_BUILD, pick_sample());
				send_word(OP_SAMPLE, pick_sample());
			end
		end

		// wind down
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d words: %0d good builds, %0d bad builds",
			words_sent, builds_ok, builds_bad);
		$display("  %0d windowed samples, %0d samples refused before any table",
			samples_ok, samples_bad);
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", fails);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
